// File: sv/asd_pkg.sv
// Shared types and constants for the audio stream subframe deframer.
package asd_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned AUDIO_W     = 22;
   localparam int unsigned AUDIO_LSB   = 6;
   localparam int unsigned CHANNEL_W   = 4;
   localparam int unsigned DISCARD_W   = 8;

   localparam logic [5:0] START_MASK   = 6'h3F;
   localparam logic [5:0] START_CODE_A = 6'h0B;
   localparam logic [5:0] START_CODE_B = 6'h0F;

   localparam logic [DISCARD_W-1:0] DISCARD_RESET = 8'd200;

   localparam logic MODE_WORD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Per-stream outcome of one transaction, seen by the top level.
   typedef struct packed {
      logic emit;          // the word produced an audio sample
      logic frame_error;   // a start word was expected and missing
      logic present;       // present flag after the word update, before a tick clear
   } lane_status_type;

endpackage

// File: sv/asd_lane.sv
// Per-stream sync tracker: discard counter, start hunt, slot counter and present flag.
module asd_lane
   import asd_pkg::*;
#(
   parameter int FRAME_WORDS = 8,
   parameter int SLOT_W      = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 hit,
   input  logic                 tick,
   input  logic                 is_start,
   input  logic                 csr_wr_en,
   input  logic [DISCARD_W-1:0] csr_wr_data,
   output logic [SLOT_W-1:0]    slot,
   output lane_status_type      status
);

   logic [DISCARD_W-1:0] discard_left_ff, discard_left_in;
   logic                 synced_ff, synced_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 present_ff, present_in;

   logic emit;
   logic frame_error;
   logic wrap;
   logic present_upd;

   always_comb begin
      emit            = 1'b0;
      frame_error     = 1'b0;
      discard_left_in = discard_left_ff;
      synced_in       = synced_ff;
      slot_in         = slot_ff;
      wrap            = (slot_ff == SLOT_W'(FRAME_WORDS - 1));
      if (csr_wr_en) begin
         discard_left_in = csr_wr_data;
      end else if (hit) begin
         if (discard_left_ff != '0) begin
            discard_left_in = discard_left_ff - 1'b1;
         end else if (!synced_ff && !is_start) begin
            // Still hunting for the first start word.
         end else if (synced_ff && (slot_ff == '0) && !is_start) begin
            frame_error = 1'b1;
         end else begin
            emit      = 1'b1;
            synced_in = 1'b1;
            slot_in   = wrap ? '0 : slot_ff + 1'b1;
         end
      end
      present_upd = present_ff | (emit & wrap);
      present_in  = tick ? 1'b0 : present_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_left_ff <= DISCARD_RESET;
         synced_ff       <= 1'b0;
         slot_ff         <= '0;
         present_ff      <= 1'b0;
      end else begin
         discard_left_ff <= discard_left_in;
         synced_ff       <= synced_in;
         slot_ff         <= slot_in;
         present_ff      <= present_in;
      end
   end

   assign slot               = slot_ff;
   assign status.emit        = emit;
   assign status.frame_error = frame_error;
   assign status.present     = present_upd;

endmodule

// File: sv/audio_stream_subframe_deframer.sv
// Top level of the audio stream subframe deframer.
//
// The req channel carries one transaction per received subframe word or per
// indicator refresh tick (req_tuser bit 0 set). Each stream first drops
// discard_count words, then hunts for a start word and, once synced, turns
// every subframe into a 22-bit sample on channel stream * FRAME_WORDS + slot.
// Every req transaction yields exactly one rsp transaction, which carries the
// sample (when rsp_tuser is set) and the error and present flags.
// The result of an accepted transaction is registered and presented on rsp
// from the next cycle. Throughput is one transaction per cycle while the
// receiver takes each result, set by the single result register; per-stream
// state updates in the same cycle the word is accepted.
// When the receiver stalls, the result register holds its transaction and
// req_tready drops until it is taken; a new transaction is taken in the same
// cycle that the held one leaves.
// Reset (synchronous) clears sync state, slots, the flags and the result valid
// flag, and reloads every discard counter with 200. A csr write reloads
// all discard counters with the new value and keeps sync state; it must only
// happen while no transaction is in flight.
module audio_stream_subframe_deframer
   import asd_pkg::*;
#(
   parameter int FRAME_WORDS = 8,
   parameter int NUM_STREAMS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [31:0] word
   input  logic [1:0]           req_tuser,   // [0] mode, [1] stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [3:0] channel, [25:4] audio, [26] error_seen,
                                             // [27] low_present, [28] high_present, [31:29] zero
   output logic                 rsp_tuser,   // [0] sample_valid
   input  logic                 csr_wr_en,
   input  logic [DISCARD_W-1:0] csr_wr_data
);

   localparam int SLOT_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

   logic req_accept;
   logic req_mode;
   logic req_stream;
   logic word_start;
   logic tick;

   logic [NUM_STREAMS-1:0] lane_hit;
   logic [SLOT_W-1:0]      lane_slot [NUM_STREAMS];
   lane_status_type        lane_status [NUM_STREAMS];

   logic              any_emit;
   logic              any_error;
   logic [SLOT_W-1:0] sel_slot;
   logic              low_present;
   logic              high_present;

   logic                 error_ff, error_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 sample_valid_ff, sample_valid_in;
   logic [CHANNEL_W-1:0] channel_ff, channel_in;
   logic [AUDIO_W-1:0]   audio_ff, audio_in;
   logic                 error_seen_ff, error_seen_in;
   logic                 low_present_ff, low_present_in;
   logic                 high_present_ff, high_present_in;

   // A new transaction enters whenever the result register is empty or drains now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_mode   = req_tuser[0];
   assign req_stream = req_tuser[1];
   assign tick       = req_accept && (req_mode == MODE_TICK);
   assign word_start = ((req_tdata[5:0] & START_MASK) == START_CODE_A) ||
                       ((req_tdata[5:0] & START_MASK) == START_CODE_B);

   for (genvar s = 0; s < NUM_STREAMS; s++) begin : g_lane
      assign lane_hit[s] = req_accept && (req_mode == MODE_WORD) &&
                           (32'(req_stream) == s);

      asd_lane #(
         .FRAME_WORDS (FRAME_WORDS),
         .SLOT_W      (SLOT_W)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .hit         (lane_hit[s]),
         .tick        (tick),
         .is_start    (word_start),
         .csr_wr_en   (csr_wr_en),
         .csr_wr_data (csr_wr_data),
         .slot        (lane_slot[s]),
         .status      (lane_status[s])
      );
   end

   // Only the addressed lane can emit or flag an error, so OR-ing is a clean select.
   always_comb begin
      any_emit  = 1'b0;
      any_error = 1'b0;
      sel_slot  = '0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         any_emit  = any_emit | lane_status[s].emit;
         any_error = any_error | lane_status[s].frame_error;
         if (lane_hit[s]) begin
            sel_slot = lane_slot[s];
         end
      end
   end

   assign low_present = lane_status[0].present;

   if (NUM_STREAMS > 1) begin : g_high
      assign high_present = lane_status[1].present;
   end else begin : g_no_high
      assign high_present = 1'b0;
   end

   always_comb begin
      error_in        = error_ff | any_error;
      rsp_valid_in    = rsp_valid_ff;
      sample_valid_in = sample_valid_ff;
      channel_in      = channel_ff;
      audio_in        = audio_ff;
      error_seen_in   = error_seen_ff;
      low_present_in  = low_present_ff;
      high_present_in = high_present_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in    = 1'b1;
         sample_valid_in = any_emit;
         channel_in      = any_emit ?
                           CHANNEL_W'(32'(req_stream) * FRAME_WORDS + 32'(sel_slot)) : '0;
         audio_in        = any_emit ? req_tdata[AUDIO_LSB +: AUDIO_W] : '0;
         error_seen_in   = error_in;
         low_present_in  = low_present;
         high_present_in = high_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_valid_ff <= sample_valid_in;
      channel_ff      <= channel_in;
      audio_ff        <= audio_in;
      error_seen_ff   <= error_seen_in;
      low_present_ff  <= low_present_in;
      high_present_ff <= high_present_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = sample_valid_ff;
   assign rsp_tdata  = {3'b000, high_present_ff, low_present_ff, error_seen_ff,
                        audio_ff, channel_ff};

endmodule
